// File: rtl/core/bpc_pkg.sv
// Shared constants and arithmetic helpers for the pressure compensation pipeline.
package bpc_pkg;

    localparam int DIV_W = 32;

    // Input register, two front stages, divider, seven middle stages,
    // divider, three back stages, output register.
    localparam int PIPE_LAT = 3 + DIV_W + 7 + DIV_W + 3 + 1;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 64;

    localparam logic [1:0] REG_COEF_A = 2'd0;
    localparam logic [1:0] REG_COEF_B = 2'd1;
    localparam logic [1:0] REG_COEF_C = 2'd2;
    localparam logic [1:0] REG_OSS    = 2'd3;

    localparam logic [3:0] UP_SHIFT_MAX = 4'd8;

    localparam logic signed [31:0] C_T_ROUND  = 32'sd8;
    localparam logic signed [31:0] C_B6_OFF   = 32'sd4000;
    localparam logic signed [31:0] C_RND2     = 32'sd2;
    localparam logic signed [31:0] C_B4_BIAS  = 32'sd32768;
    localparam logic [15:0]        C_P_SCALE  = 16'd50000;
    localparam logic signed [31:0] C_P_K1     = 32'sd3038;
    localparam logic signed [31:0] C_P_K2     = -32'sd7357;
    localparam logic signed [31:0] C_P_K3     = 32'sd3791;
    localparam logic signed [31:0] C_T_MAX    = 32'sd32767;
    localparam logic signed [31:0] C_T_MIN    = -32'sd32768;
    localparam logic signed [31:0] C_P_MAX    = 32'sd1048575;

    // Signed divide by 2**k, truncating toward zero.
    function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] a,
                                                   input int unsigned k);
        logic signed [31:0] bias;
        bias = a[31] ? ((32'sd1 <<< k) - 32'sd1) : 32'sd0;
        return (a + bias) >>> k;
    endfunction

    // Signed 32x32 product wrapped to 32 bits.
    function automatic logic signed [31:0] mul32(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        return p[31:0];
    endfunction

    function automatic logic [31:0] mag32(input logic signed [31:0] a);
        return a[31] ? 32'(-a) : 32'(a);
    endfunction

endpackage

// File: rtl/core/bpc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module bpc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [bpc_pkg::DIV_W-1:0]   i_num,
    input  logic [bpc_pkg::DIV_W-1:0]   i_den,
    output logic                        o_valid,
    output logic [bpc_pkg::DIV_W-1:0]   o_quo
);
    localparam int W = bpc_pkg::DIV_W;

    logic [W-1:0] r_rem [W];
    logic [W-1:0] r_num [W];
    logic [W-1:0] r_den [W];
    logic [W-1:0] r_quo [W];
    logic         r_vld [W];

    logic [W-1:0] c_rem [W];
    logic [W-1:0] c_num [W];
    logic [W-1:0] c_den [W];
    logic [W-1:0] c_quo [W];
    logic         c_vld [W];
    logic [W:0]   w_sh  [W];
    logic [W-1:0] n_rem [W];
    logic [W-1:0] n_quo [W];

    always_comb begin
        for (int s = 0; s < W; s++) begin
            c_rem[s] = (s == 0) ? '0      : r_rem[s-1];
            c_num[s] = (s == 0) ? i_num   : r_num[s-1];
            c_den[s] = (s == 0) ? i_den   : r_den[s-1];
            c_quo[s] = (s == 0) ? '0      : r_quo[s-1];
            c_vld[s] = (s == 0) ? i_valid : r_vld[s-1];
            w_sh[s]  = {c_rem[s], c_num[s][W-1]};
            // Subtract when the shifted remainder covers the divisor.
            if (w_sh[s] >= {1'b0, c_den[s]}) begin
                n_rem[s] = W'(w_sh[s] - {1'b0, c_den[s]});
                n_quo[s] = {c_quo[s][W-2:0], 1'b1};
            end else begin
                n_rem[s] = w_sh[s][W-1:0];
                n_quo[s] = {c_quo[s][W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < W; s++) begin
            r_rem[s] <= n_rem[s];
            r_num[s] <= {c_num[s][W-2:0], 1'b0};
            r_den[s] <= c_den[s];
            r_quo[s] <= n_quo[s];
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= c_vld[s];
            end
        end
    end

    assign o_valid = r_vld[W-1];
    assign o_quo   = r_quo[W-1];

endmodule

// File: rtl/core/barometric_pressure_compensation.sv
// Top level of the barometric pressure compensation pipeline.
//
//  channel   | direction | handshake              | beat contents
//  ----------+-----------+------------------------+-----------------------------------
//  sample    | in        | start high, busy low   | raw temperature, raw pressure bytes
//  result    | out       | o_valid, one cycle     | temperature, pressure, two flags
//  config    | in/out    | APB write/read, 64 bit | coef words A, B, C and oversampling
//
//  One sample enters per cycle while busy is low; each result passes through
//  two 32-stage dividers, one for the temperature term X2 and one for the
//  pressure quotient, plus thirteen arithmetic stages and the output register.
//  Reset is synchronous and clears every valid bit; busy is high only in reset.
//  The result side cannot stall, so the pipeline advances every cycle.
module barometric_pressure_compensation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0]    paddr,
    input  logic [bpc_pkg::DATA_W-1:0]    pwdata,
    output logic [bpc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic [15:0]                   i_raw_temperature,
    input  logic [23:0]                   i_raw_pressure_bytes,
    output logic                          o_valid,
    output logic signed [15:0]            o_temperature_tenths,
    output logic [19:0]                   o_pressure_pa,
    output logic                          o_divide_error,
    output logic                          o_out_of_range
);
    localparam int W = bpc_pkg::DIV_W;

    // Sideband that rides alongside each divider.
    typedef struct packed {
        logic signed [31:0] x1;
        logic               neg;
        logic               err;
        logic [18:0]        up;
    } t_side_a;

    typedef struct packed {
        logic               top;
        logic signed [31:0] temp;
        logic               err;
    } t_side_b;

    // ---------------------------------------------------------------- config
    logic [63:0] r_coef_a;
    logic [63:0] r_coef_b;
    logic [31:0] r_coef_c;
    logic [1:0]  r_oss;
    logic        r_busy;
    logic        w_wr;

    assign w_wr   = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_a <= '0;
            r_coef_b <= '0;
            r_coef_c <= '0;
            r_oss    <= '0;
            r_busy   <= 1'b1;
        end else begin
            r_busy <= 1'b0;
            if (w_wr) begin
                case (paddr[4:3])
                    bpc_pkg::REG_COEF_A: r_coef_a <= pwdata;
                    bpc_pkg::REG_COEF_B: r_coef_b <= pwdata;
                    bpc_pkg::REG_COEF_C: r_coef_c <= pwdata[31:0];
                    bpc_pkg::REG_OSS:    r_oss    <= pwdata[1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb begin
        case (paddr[4:3])
            bpc_pkg::REG_COEF_A: prdata = r_coef_a;
            bpc_pkg::REG_COEF_B: prdata = r_coef_b;
            bpc_pkg::REG_COEF_C: prdata = {32'd0, r_coef_c};
            bpc_pkg::REG_OSS:    prdata = {62'd0, r_oss};
            default:             prdata = '0;
        endcase
    end

    assign busy = r_busy;

    // Calibration words; the user must hold them steady while samples are in flight (not enforced here).
    logic signed [15:0] w_ac1, w_ac2, w_ac3, w_b1, w_b2, w_mc, w_md;
    logic [15:0]        w_ac4, w_ac5, w_ac6;

    assign w_ac1 = r_coef_a[63:48];
    assign w_ac2 = r_coef_a[47:32];
    assign w_ac3 = r_coef_a[31:16];
    assign w_ac4 = r_coef_a[15:0];
    assign w_ac5 = r_coef_b[63:48];
    assign w_ac6 = r_coef_b[47:32];
    assign w_b1  = r_coef_b[31:16];
    assign w_b2  = r_coef_b[15:0];
    assign w_mc  = r_coef_c[31:16];
    assign w_md  = r_coef_c[15:0];

    // --------------------------------------------------- stage 1: capture
    logic               w_acc;
    logic [23:0]        w_up_full;
    logic               r1_valid;
    logic signed [16:0] r1_dt;
    logic [18:0]        r1_up;

    assign w_acc     = start && !busy;
    // Align pressure: drop 8 - OSS low bits.
    assign w_up_full = i_raw_pressure_bytes >> (bpc_pkg::UP_SHIFT_MAX - {2'b00, r_oss});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= w_acc;
        end
        r1_dt <= $signed({1'b0, i_raw_temperature}) - $signed({1'b0, w_ac6});
        r1_up <= w_up_full[18:0];
    end

    // --------------------------------------------------- stage 2: (UT-AC6)*AC5
    logic               r2_valid;
    logic signed [31:0] r2_prod;
    logic [18:0]        r2_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
        r2_prod <= bpc_pkg::mul32(32'(r1_dt), $signed({16'd0, w_ac5}));
        r2_up   <= r1_up;
    end

    // --------------------------------------------------- stage 3: X1, MD, divisor prep
    logic signed [31:0] w3_x1, w3_den, w3_num;
    logic               r3_valid;
    logic signed [31:0] r3_x1;
    logic [31:0]        r3_num_mag, r3_den_mag;
    logic               r3_neg, r3_err;
    logic [18:0]        r3_up;

    assign w3_x1  = bpc_pkg::sdiv_p2(r2_prod, 15);
    assign w3_den = w3_x1 + 32'(w_md);
    assign w3_num = 32'(w_mc) <<< 11;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
        r3_x1      <= w3_x1;
        r3_num_mag <= bpc_pkg::mag32(w3_num);
        r3_den_mag <= bpc_pkg::mag32(w3_den);
        r3_neg     <= w3_num[31] ^ w3_den[31];
        r3_err     <= (w3_den == 32'sd0);
        r3_up      <= r2_up;
    end

    // --------------------------------------------------- divider A: MC*2048 / (X1+MD)
    logic        w_da_vld;
    logic [31:0] w_da_quo;
    t_side_a     r_sa [W];

    bpc_div u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r3_valid),
        .i_num   (r3_num_mag),
        .i_den   (r3_den_mag),
        .o_valid (w_da_vld),
        .o_quo   (w_da_quo)
    );

    always_ff @(posedge i_clk) begin
        r_sa[0] <= '{x1: r3_x1, neg: r3_neg, err: r3_err, up: r3_up};
        for (int i = 1; i < W; i++) begin
            r_sa[i] <= r_sa[i-1];
        end
    end

    // --------------------------------------------------- stage 4: B5, temperature, B6
    logic signed [31:0] w4_x2, w4_b5;
    logic               r4_valid, r4_err;
    logic signed [31:0] r4_temp, r4_b6;
    logic [18:0]        r4_up;

    assign w4_x2 = r_sa[W-1].neg ? -$signed(w_da_quo) : $signed(w_da_quo);
    assign w4_b5 = r_sa[W-1].x1 + w4_x2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else begin
            r4_valid <= w_da_vld;
        end
        r4_temp <= bpc_pkg::sdiv_p2(w4_b5 + bpc_pkg::C_T_ROUND, 4);
        r4_b6   <= w4_b5 - bpc_pkg::C_B6_OFF;
        r4_err  <= r_sa[W-1].err;
        r4_up   <= r_sa[W-1].up;
    end

    // --------------------------------------------------- stage 5: B6 products
    logic               r5_valid, r5_err;
    logic signed [31:0] r5_sqp, r5_p2, r5_p3, r5_temp;
    logic [18:0]        r5_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else begin
            r5_valid <= r4_valid;
        end
        r5_sqp  <= bpc_pkg::mul32(r4_b6, r4_b6);
        r5_p2   <= bpc_pkg::mul32(32'(w_ac2), r4_b6);
        r5_p3   <= bpc_pkg::mul32(32'(w_ac3), r4_b6);
        r5_temp <= r4_temp;
        r5_err  <= r4_err;
        r5_up   <= r4_up;
    end

    // --------------------------------------------------- stage 6: scale products
    logic               r6_valid, r6_err;
    logic signed [31:0] r6_sq, r6_x2, r6_x1, r6_temp;
    logic [18:0]        r6_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else begin
            r6_valid <= r5_valid;
        end
        r6_sq   <= bpc_pkg::sdiv_p2(r5_sqp, 12);
        r6_x2   <= bpc_pkg::sdiv_p2(r5_p2, 11);
        r6_x1   <= bpc_pkg::sdiv_p2(r5_p3, 13);
        r6_temp <= r5_temp;
        r6_err  <= r5_err;
        r6_up   <= r5_up;
    end

    // --------------------------------------------------- stage 7: B1, B2 times square
    logic               r7_valid, r7_err;
    logic signed [31:0] r7_p2, r7_p1, r7_x2, r7_x1, r7_temp;
    logic [18:0]        r7_up;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else begin
            r7_valid <= r6_valid;
        end
        r7_p2   <= bpc_pkg::mul32(32'(w_b2), r6_sq);
        r7_p1   <= bpc_pkg::mul32(32'(w_b1), r6_sq);
        r7_x2   <= r6_x2;
        r7_x1   <= r6_x1;
        r7_temp <= r6_temp;
        r7_err  <= r6_err;
        r7_up   <= r6_up;
    end

    // --------------------------------------------------- stage 8: B3 and B4 operand
    logic signed [31:0] w8_x3, w8_b3a, w8_b3s, w8_xb, w8_x3b;
    logic               r8_valid, r8_err;
    logic signed [31:0] r8_b3, r8_t, r8_temp;
    logic [18:0]        r8_up;

    assign w8_x3  = bpc_pkg::sdiv_p2(r7_p2, 11) + r7_x2;
    assign w8_b3a = (32'(w_ac1) <<< 2) + w8_x3;
    assign w8_b3s = w8_b3a << r_oss;
    assign w8_xb  = bpc_pkg::sdiv_p2(r7_p1, 16);
    assign w8_x3b = bpc_pkg::sdiv_p2(r7_x1 + w8_xb + bpc_pkg::C_RND2, 2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
        end else begin
            r8_valid <= r7_valid;
        end
        r8_b3   <= bpc_pkg::sdiv_p2(w8_b3s + bpc_pkg::C_RND2, 2);
        r8_t    <= w8_x3b + bpc_pkg::C_B4_BIAS;
        r8_temp <= r7_temp;
        r8_err  <= r7_err;
        r8_up   <= r7_up;
    end

    // --------------------------------------------------- stage 9: B4, UP-B3
    logic [47:0]        w9_p;
    logic               r9_valid, r9_err;
    logic [16:0]        r9_b4;
    logic [31:0]        r9_diff;
    logic signed [31:0] r9_temp;

    assign w9_p = w_ac4 * 32'(r8_t);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_valid <= 1'b0;
        end else begin
            r9_valid <= r8_valid;
        end
        r9_b4   <= w9_p[31:15];
        r9_diff <= {13'd0, r8_up} - 32'(r8_b3);
        r9_temp <= r8_temp;
        r9_err  <= r8_err;
    end

    // --------------------------------------------------- stage 10: B7
    logic [15:0]        w10_scale;
    logic [47:0]        w10_p;
    logic               r10_valid, r10_err;
    logic [31:0]        r10_b7;
    logic [16:0]        r10_b4;
    logic signed [31:0] r10_temp;

    assign w10_scale = bpc_pkg::C_P_SCALE >> r_oss;
    assign w10_p     = r9_diff * w10_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r10_valid <= 1'b0;
        end else begin
            r10_valid <= r9_valid;
        end
        r10_b7   <= w10_p[31:0];
        r10_b4   <= r9_b4;
        r10_temp <= r9_temp;
        r10_err  <= r9_err || (r9_b4 == 17'd0);
    end

    // --------------------------------------------------- divider B: B7 / B4
    // Double B7 before dividing unless its top bit is set; then double after.
    logic [31:0] w_db_num;
    logic        w_db_vld;
    logic [31:0] w_db_quo;
    t_side_b     r_sb [W];

    assign w_db_num = r10_b7[31] ? r10_b7 : {r10_b7[30:0], 1'b0};

    bpc_div u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r10_valid),
        .i_num   (w_db_num),
        .i_den   ({15'd0, r10_b4}),
        .o_valid (w_db_vld),
        .o_quo   (w_db_quo)
    );

    always_ff @(posedge i_clk) begin
        r_sb[0] <= '{top: r10_b7[31], temp: r10_temp, err: r10_err};
        for (int i = 1; i < W; i++) begin
            r_sb[i] <= r_sb[i-1];
        end
    end

    // --------------------------------------------------- stage 11: raw pressure
    logic signed [31:0] w11_pres;
    logic               r11_valid, r11_err;
    logic signed [31:0] r11_pres, r11_pd, r11_temp;

    assign w11_pres = r_sb[W-1].top ? $signed({w_db_quo[30:0], 1'b0}) : $signed(w_db_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r11_valid <= 1'b0;
        end else begin
            r11_valid <= w_db_vld;
        end
        r11_pres <= w11_pres;
        r11_pd   <= bpc_pkg::sdiv_p2(w11_pres, 8);
        r11_temp <= r_sb[W-1].temp;
        r11_err  <= r_sb[W-1].err;
    end

    // --------------------------------------------------- stage 12: pressure products
    logic               r12_valid, r12_err;
    logic signed [31:0] r12_sq, r12_m2, r12_pres, r12_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r12_valid <= 1'b0;
        end else begin
            r12_valid <= r11_valid;
        end
        r12_sq   <= bpc_pkg::mul32(r11_pd, r11_pd);
        r12_m2   <= bpc_pkg::mul32(bpc_pkg::C_P_K2, r11_pres);
        r12_pres <= r11_pres;
        r12_temp <= r11_temp;
        r12_err  <= r11_err;
    end

    // --------------------------------------------------- stage 13: square times 3038
    logic               r13_valid, r13_err;
    logic signed [31:0] r13_m1, r13_x2, r13_pres, r13_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r13_valid <= 1'b0;
        end else begin
            r13_valid <= r12_valid;
        end
        r13_m1   <= bpc_pkg::mul32(r12_sq, bpc_pkg::C_P_K1);
        r13_x2   <= bpc_pkg::sdiv_p2(r12_m2, 16);
        r13_pres <= r12_pres;
        r13_temp <= r12_temp;
        r13_err  <= r12_err;
    end

    // --------------------------------------------------- output: correct, clamp, drive
    logic signed [31:0] w_sum, w_pfin;
    logic               w_t_hi, w_t_lo, w_p_hi, w_p_lo;
    logic signed [15:0] w_temp_sat;
    logic [19:0]        w_pres_sat;

    assign w_sum  = bpc_pkg::sdiv_p2(r13_m1, 16) + r13_x2 + bpc_pkg::C_P_K3;
    assign w_pfin = r13_pres + bpc_pkg::sdiv_p2(w_sum, 4);
    assign w_t_hi = r13_temp > bpc_pkg::C_T_MAX;
    assign w_t_lo = r13_temp < bpc_pkg::C_T_MIN;
    assign w_p_hi = w_pfin > bpc_pkg::C_P_MAX;
    assign w_p_lo = w_pfin[31];

    always_comb begin
        if (w_t_hi) begin
            w_temp_sat = bpc_pkg::C_T_MAX[15:0];
        end else if (w_t_lo) begin
            w_temp_sat = bpc_pkg::C_T_MIN[15:0];
        end else begin
            w_temp_sat = r13_temp[15:0];
        end
        if (w_p_hi) begin
            w_pres_sat = bpc_pkg::C_P_MAX[19:0];
        end else if (w_p_lo) begin
            w_pres_sat = '0;
        end else begin
            w_pres_sat = w_pfin[19:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r13_valid;
        end
        // Drop both results to zero on a zero divisor.
        if (r13_err) begin
            o_temperature_tenths <= '0;
            o_pressure_pa        <= '0;
            o_out_of_range       <= 1'b0;
        end else begin
            o_temperature_tenths <= w_temp_sat;
            o_pressure_pa        <= w_pres_sat;
            o_out_of_range       <= w_t_hi || w_t_lo || w_p_hi || w_p_lo;
        end
        o_divide_error <= r13_err;
    end

endmodule

// File: rtl/core/bpc_chk.sv
// Port-level checker for the pressure compensation block, with its bind.
module bpc_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpc_pkg::ADDR_W-1:0]    paddr,
    input  logic [bpc_pkg::DATA_W-1:0]    pwdata,
    input  logic [bpc_pkg::DATA_W-1:0]    prdata,
    input  logic                          pready,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          o_valid,
    input  logic signed [15:0]            o_temperature_tenths,
    input  logic [19:0]                   o_pressure_pa,
    input  logic                          o_divide_error,
    input  logic                          o_out_of_range
);

    // Every result traces back to a sample beat a fixed latency earlier.
    a_result_has_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, bpc_pkg::PIPE_LAT))
        else $error("result without matching sample beat");

    // A zero divisor forces zero results and no range flag.
    a_div_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_error) |->
            (o_temperature_tenths == 16'sd0 && o_pressure_pa == 20'd0 && !o_out_of_range))
        else $error("divide error with nonzero results");

    // A write to the first coefficient word reads back next cycle.
    a_coef_a_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable && pwrite && pready && paddr[4:3] == bpc_pkg::REG_COEF_A) |=>
            (paddr != $past(paddr) || prdata == $past(pwdata)))
        else $error("coefficient word A readback mismatch");

endmodule

bind barometric_pressure_compensation bpc_chk u_bpc_chk (.*);
